@@ sv/dssc_pkg.sv @@
// Shared types, constants and font helpers for the dual seven-segment scan controller.
package dssc_pkg;

  localparam int NumDigits = 4;
  localparam int PosW      = $clog2(NumDigits);

  // APB register map: register index is paddr[PaddrW-1].
  localparam int            PaddrW         = 3;
  localparam logic          RegCommonAnode = 1'b0;

  localparam logic [7:0]    OffAnode   = 8'hFF;
  localparam logic [7:0]    OffCathode = 8'h00;

  // Reciprocal multipliers for divide by 100 (exact over the ranges used).
  localparam logic [12:0]   Div100Mul16   = 13'd5243;  // 16-bit value >> 2, shift 17
  localparam logic [5:0]    Div100Mul10   = 6'd41;     // 10-bit value, shift 12

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdNumber  = 2'd1,
    CmdPattern = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       display_select;
    logic [2:0] digit_index;
    logic [7:0] pattern;
  } item_t;

  typedef logic [NumDigits-1:0][7:0] store_t;

  function automatic logic [7:0] font(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h27;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // 0..99 to {tens, ones}; parallel threshold compares, no divider.
  function automatic logic [7:0] pair_to_bcd(input logic [6:0] x);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = x - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] drive_byte(input logic [7:0] b, input logic common_anode);
    return common_anode ? ~b : b;
  endfunction

endpackage

@@ sv/dssc_regs.sv @@
// APB configuration register: display polarity.
module dssc_regs import dssc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic              common_anode_o
);

  logic common_anode_q, common_anode_d;
  logic hit;

  assign hit    = (paddr[PaddrW-1] == RegCommonAnode);
  assign pready = 1'b1;
  assign prdata = hit ? {31'b0, common_anode_q} : 32'b0;

  always_comb begin
    common_anode_d = common_anode_q;
    if (psel && penable && pwrite && hit) begin
      common_anode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_anode_q <= 1'b1;
    end else begin
      common_anode_q <= common_anode_d;
    end
  end

  assign common_anode_o = common_anode_q;

endmodule

@@ sv/dssc_split.sv @@
// Input register and decimal split pipeline: number mod 10000 into two 0..99 pairs.
module dssc_split import dssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  item_t       in_item_i,
  input  logic [15:0] in_number_i,
  output logic        out_valid_o,
  output item_t       out_item_o,
  output logic [6:0]  out_pair_hi_o,
  output logic [6:0]  out_pair_lo_o
);

  // stage 0: input word
  logic        valid0_q;
  item_t       item0_q;
  logic [15:0] num0_q;
  // stage 1: n / 100
  logic        valid1_q;
  item_t       item1_q;
  logic [15:0] num1_q;
  logic [9:0]  quot1_q;
  // stage 2: n % 100, (n / 100) / 100
  logic        valid2_q;
  item_t       item2_q;
  logic [6:0]  rem2_q;
  logic [9:0]  quot2_q;
  logic [2:0]  thou2_q;
  // stage 3: both pairs
  logic        valid3_q;
  item_t       item3_q;
  logic [6:0]  lo3_q;
  logic [6:0]  hi3_q;

  logic [26:0] prod0;
  logic [14:0] prod1;
  logic [15:0] quot1_x100;
  logic [15:0] rem1;
  logic [9:0]  thou2_x100;
  logic [9:0]  hi2;

  // n / 100 as (n >> 2) / 25
  assign prod0      = {13'b0, num0_q[15:2]} * {14'b0, Div100Mul16};
  assign prod1      = {5'b0, quot1_q} * {9'b0, Div100Mul10};
  assign quot1_x100 = {6'b0, quot1_q} * 16'd100;
  assign rem1       = num1_q - quot1_x100;
  assign thou2_x100 = {7'b0, thou2_q} * 10'd100;
  assign hi2        = quot2_q - thou2_x100;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid0_q <= in_valid_i;
      valid1_q <= valid0_q;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item0_q <= in_item_i;
    num0_q  <= in_number_i;
    item1_q <= item0_q;
    num1_q  <= num0_q;
    quot1_q <= prod0[26:17];
    item2_q <= item1_q;
    rem2_q  <= rem1[6:0];
    quot2_q <= quot1_q;
    thou2_q <= prod1[14:12];
    item3_q <= item2_q;
    lo3_q   <= rem2_q;
    hi3_q   <= hi2[6:0];
  end

  assign out_valid_o   = valid3_q;
  assign out_item_o    = item3_q;
  assign out_pair_hi_o = hi3_q;
  assign out_pair_lo_o = lo3_q;

  // Both pairs must be two-digit values or the font lookup would be wrong.
  a_pairs_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q |-> (lo3_q < 7'd100) && (hi3_q < 7'd100))
    else $error("decimal pair out of range");

endmodule

@@ sv/dssc_scan.sv @@
// Digit stores, shared scan position and segment/enable latches.
module dssc_scan import dssc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  item_t                in_item_i,
  input  logic [6:0]           pair_hi_i,
  input  logic [6:0]           pair_lo_i,
  input  logic                 common_anode_i,
  output logic                 done_o,
  output logic [7:0]           segments_first_o,
  output logic [7:0]           segments_second_o,
  output logic [NumDigits-1:0] digit_enables_o,
  output logic [PosW-1:0]      lit_digit_o
);

  store_t               first_q, first_d;
  store_t               second_q, second_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [7:0]           seg_first_q, seg_first_d;
  logic [7:0]           seg_second_q, seg_second_d;
  logic [NumDigits-1:0] en_q, en_d;
  logic                 done_q;

  logic [7:0]           bcd_hi, bcd_lo, off;
  store_t               num_bytes, cur, upd;
  logic [PosW-1:0]      pos_next;
  logic [NumDigits-1:0] onehot;
  logic                 tick, write;

  assign off    = common_anode_i ? OffAnode : OffCathode;
  assign bcd_hi = pair_to_bcd(pair_hi_i);
  assign bcd_lo = pair_to_bcd(pair_lo_i);

  // index 0 is the thousands digit, the ones digit sits at the highest index
  assign num_bytes[0] = drive_byte(font(bcd_hi[7:4]), common_anode_i);
  assign num_bytes[1] = drive_byte(font(bcd_hi[3:0]), common_anode_i);
  assign num_bytes[2] = drive_byte(font(bcd_lo[7:4]), common_anode_i);
  assign num_bytes[3] = drive_byte(font(bcd_lo[3:0]), common_anode_i);

  assign tick  = in_valid_i && (in_item_i.cmd == CmdTick);
  assign write = in_valid_i && (in_item_i.cmd != CmdTick);
  assign cur   = in_item_i.display_select ? second_q : first_q;

  always_comb begin
    upd = cur;
    case (in_item_i.cmd)
      CmdNumber: begin
        upd = num_bytes;
      end
      CmdPattern: begin
        if (in_item_i.digit_index < 3'(NumDigits)) begin
          upd[in_item_i.digit_index[PosW-1:0]] =
            drive_byte(in_item_i.pattern, common_anode_i);
        end
      end
      CmdClear: begin
        for (int i = 0; i < NumDigits; i++) begin
          upd[i] = off;
        end
      end
      default: begin
      end
    endcase
  end

  assign first_d  = (write && !in_item_i.display_select) ? upd : first_q;
  assign second_d = (write &&  in_item_i.display_select) ? upd : second_q;

  assign pos_next = (pos_q == PosW'(NumDigits - 1)) ? '0 : pos_q + 1'b1;
  assign onehot   = NumDigits'(1) << pos_next;

  always_comb begin
    pos_d        = pos_q;
    seg_first_d  = seg_first_q;
    seg_second_d = seg_second_q;
    en_d         = en_q;
    if (tick) begin
      pos_d        = pos_next;
      seg_first_d  = first_q[pos_next];
      seg_second_d = second_q[pos_next];
      en_d         = common_anode_i ? onehot : ~onehot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        first_q[i]  <= OffAnode;
        second_q[i] <= OffAnode;
      end
      pos_q        <= '0;
      seg_first_q  <= OffAnode;
      seg_second_q <= OffAnode;
      en_q         <= '0;
      done_q       <= 1'b0;
    end else begin
      first_q      <= first_d;
      second_q     <= second_d;
      pos_q        <= pos_d;
      seg_first_q  <= seg_first_d;
      seg_second_q <= seg_second_d;
      en_q         <= en_d;
      done_q       <= in_valid_i;
    end
  end

  assign done_o            = done_q;
  assign segments_first_o  = seg_first_q;
  assign segments_second_o = seg_second_q;
  assign digit_enables_o   = en_q;
  assign lit_digit_o       = pos_q;

  a_tick_latches_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> (seg_first_q == first_q[pos_q]) && (seg_second_q == second_q[pos_q]))
    else $error("latched segments differ from store at new scan position");

  a_write_keeps_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write |=> $stable(pos_q) && $stable(en_q) && $stable(seg_first_q))
    else $error("store write disturbed scan state");

  a_one_word_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |=> done_q)
    else $error("item produced no result");

  a_enables_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(en_q) || $onehot(~en_q) || (en_q == '0))
    else $error("digit enables not a single active digit");

endmodule

@@ sv/dual_seven_segment_scan_controller_top.sv @@
// Top level of the dual seven-segment scan controller.
//
// Drives two four-digit seven-segment displays that share one scan position.
// A command word is taken on every clock edge where start is high; busy is
// always low, so the block accepts one word per cycle with no gaps. Every
// word yields one result word, shown for exactly one cycle with done_o high;
// the receiver cannot stall it. Between the accepting edge and the result
// lie the decimal split pipeline (input register, divide by 100 by
// reciprocal multiply, remainders, pairs) and the store/latch stage.
// Commands: scan tick advances the lit digit and latches both displays' bytes
// and the enables; set number writes number mod 10000 through the digit font
// (ones digit at index 3); set pattern writes a raw byte at digit_index
// (indexes 4..7 are ignored); clear writes the off pattern. The result word
// always carries the latched state after that command. Polarity (register 0,
// common_anode, reset 1) applies to later writes, clears and ticks only.
// Change it only while no command is in flight.
module dual_seven_segment_scan_controller_top import dssc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command port
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd_i,
  input  logic                 display_select_i,
  input  logic [2:0]           digit_index_i,
  input  logic [7:0]           pattern_i,
  input  logic [15:0]          number_i,
  // result port
  output logic                 done_o,
  output logic [7:0]           segments_first_o,
  output logic [7:0]           segments_second_o,
  output logic [NumDigits-1:0] digit_enables_o,
  output logic [PosW-1:0]      lit_digit_o,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  item_t      in_item;
  logic       in_valid;
  logic       common_anode;

  logic       sp_valid;
  item_t      sp_item;
  logic [6:0] sp_pair_hi;
  logic [6:0] sp_pair_lo;

  // Fully pipelined: never back-pressures the command source.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  assign in_item.cmd            = cmd_e'(cmd_i);
  assign in_item.display_select = display_select_i;
  assign in_item.digit_index    = digit_index_i;
  assign in_item.pattern        = pattern_i;

  dssc_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .common_anode_o (common_anode)
  );

  // Word and number travel together, so stores see commands in order.
  dssc_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_item_i     (in_item),
    .in_number_i   (number_i),
    .out_valid_o   (sp_valid),
    .out_item_o    (sp_item),
    .out_pair_hi_o (sp_pair_hi),
    .out_pair_lo_o (sp_pair_lo)
  );

  dssc_scan u_scan (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (sp_valid),
    .in_item_i         (sp_item),
    .pair_hi_i         (sp_pair_hi),
    .pair_lo_i         (sp_pair_lo),
    .common_anode_i    (common_anode),
    .done_o            (done_o),
    .segments_first_o  (segments_first_o),
    .segments_second_o (segments_second_o),
    .digit_enables_o   (digit_enables_o),
    .lit_digit_o       (lit_digit_o)
  );

endmodule

@@ tb/tb_dual_seven_segment_scan_controller_top.sv @@
// Self-checking testbench for the dual seven-segment scan controller top level.
`timescale 1ns / 100ps

module tb_dual_seven_segment_scan_controller_top;
  import dssc_pkg::*;

  // Expected contents of one result word.
  typedef struct packed {
    logic [7:0]           seg_first;
    logic [7:0]           seg_second;
    logic [NumDigits-1:0] enables;
    logic [PosW-1:0]      lit;
  } scan_word_t;

  // Byte address of the polarity register: register index sits in paddr[PaddrW-1].
  localparam logic [PaddrW-1:0] AddrCommonAnode = {RegCommonAnode, 2'b00};
  localparam int                CycleLimit      = 100000;
  localparam int                SettleCycles    = 8;   // split pipeline is 4 deep
  localparam int                RandomPhases    = 5;
  localparam int                PhaseWords      = 160;

  // Scoreboard: keeps its own copy of both digit stores, the scan position,
  // the latches and the polarity, and queues the result word that each
  // accepted command word should produce.
  class scan_predictor;
    bit                   anode;
    logic [7:0]           first_bytes[NumDigits];
    logic [7:0]           second_bytes[NumDigits];
    logic [PosW-1:0]      pos;
    logic [7:0]           first_latch;
    logic [7:0]           second_latch;
    logic [NumDigits-1:0] enables;
    scan_word_t           awaited[$];
    int                   errors;

    function new();
      anode = 1'b1;
      for (int i = 0; i < NumDigits; i++) begin
        first_bytes[i]  = OffAnode;
        second_bytes[i] = OffAnode;
      end
      pos          = '0;
      first_latch  = OffAnode;
      second_latch = OffAnode;
      enables      = '0;
      errors       = 0;
    endfunction

    function logic [7:0] glyph(int d);
      logic [7:0] g;
      case (d)
        0:       g = 8'h3F;
        1:       g = 8'h06;
        2:       g = 8'h5B;
        3:       g = 8'h4F;
        4:       g = 8'h66;
        5:       g = 8'h6D;
        6:       g = 8'h7D;
        7:       g = 8'h27;
        8:       g = 8'h7F;
        default: g = 8'h67;
      endcase
      return g;
    endfunction

    function logic [7:0] polar(logic [7:0] b);
      return anode ? ~b : b;
    endfunction

    function void put_byte(logic sel, int i, logic [7:0] b);
      if (sel) begin
        second_bytes[i] = b;
      end else begin
        first_bytes[i] = b;
      end
    endfunction

    function void set_polarity(bit v);
      anode = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_command(cmd_e cmd, logic sel, logic [2:0] idx, logic [7:0] pat,
                               logic [15:0] num);
      int                   n;
      logic [NumDigits-1:0] onehot;
      scan_word_t           w;
      case (cmd)
        CmdTick: begin
          pos          = PosW'((int'(pos) + 1) % NumDigits);
          first_latch  = first_bytes[pos];
          second_latch = second_bytes[pos];
          onehot       = NumDigits'(1) << pos;
          enables      = anode ? onehot : ~onehot;
        end
        CmdNumber: begin
          // ones digit lands at the highest index
          n = num;
          for (int i = NumDigits - 1; i >= 0; i--) begin
            put_byte(sel, i, polar(glyph(n % 10)));
            n = n / 10;
          end
        end
        CmdPattern: begin
          if (idx < NumDigits) begin
            put_byte(sel, idx, polar(pat));
          end
        end
        default: begin
          for (int i = 0; i < NumDigits; i++) begin
            put_byte(sel, i, anode ? OffAnode : OffCathode);
          end
        end
      endcase
      w.seg_first  = first_latch;
      w.seg_second = second_latch;
      w.enables    = enables;
      w.lit        = pos;
      awaited.push_back(w);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
    endtask

    task check_word(logic [7:0] sf, logic [7:0] ss, logic [NumDigits-1:0] en,
                    logic [PosW-1:0] lit);
      scan_word_t w;
      if (awaited.size() == 0) begin
        report("result word with none expected");
        return;
      end
      w = awaited.pop_front();
      if (sf !== w.seg_first) begin
        report($sformatf("segments_first %h, expected %h", sf, w.seg_first));
      end
      if (ss !== w.seg_second) begin
        report($sformatf("segments_second %h, expected %h", ss, w.seg_second));
      end
      if (en !== w.enables) begin
        report($sformatf("digit_enables %b, expected %b", en, w.enables));
      end
      if (lit !== w.lit) begin
        report($sformatf("lit_digit %0d, expected %0d", lit, w.lit));
      end
    endtask
  endclass

  // Clock, reset and all block inputs start at known values.
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic [1:0]           cmd_i = CmdTick;
  logic                 display_select_i = 1'b0;
  logic [2:0]           digit_index_i = '0;
  logic [7:0]           pattern_i = '0;
  logic [15:0]          number_i = '0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PaddrW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;

  logic                 busy;
  logic                 done_o;
  logic [7:0]           segments_first_o;
  logic [7:0]           segments_second_o;
  logic [NumDigits-1:0] digit_enables_o;
  logic [PosW-1:0]      lit_digit_o;
  logic [31:0]          prdata;
  logic                 pready;

  scan_predictor        sb = new();
  int                   cycles = 0;

  always #5 clk_i = ~clk_i;

  dual_seven_segment_scan_controller_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cmd_i             (cmd_i),
    .display_select_i  (display_select_i),
    .digit_index_i     (digit_index_i),
    .pattern_i         (pattern_i),
    .number_i          (number_i),
    .done_o            (done_o),
    .segments_first_o  (segments_first_o),
    .segments_second_o (segments_second_o),
    .digit_enables_o   (digit_enables_o),
    .lit_digit_o       (lit_digit_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Monitor. Everything read here holds its pre-edge value, so a result
  // word is checked and a command word noted exactly as the block saw them.
  // The check runs first: a word accepted at this edge cannot already have
  // a result out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_word(segments_first_o, segments_second_o, digit_enables_o, lit_digit_o);
      end
      if (start && !busy) begin
        sb.note_command(cmd_e'(cmd_i), display_select_i, digit_index_i, pattern_i,
                        number_i);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_dual_seven_segment_scan_controller_top: done, errors");
      $finish;
    end
  end

  // Present one command word and hold it until the block takes it. busy is
  // sampled mid-cycle, where it is stable, to decide whether the coming edge
  // accepts the word. Called just after a rising edge; returns just after the
  // accepting edge, so a following word can be driven in the same step.
  task automatic send_word(cmd_e c, logic sel, logic [2:0] idx, logic [7:0] pat,
                           logic [15:0] num);
    logic stalled;
    start            <= 1'b1;
    cmd_i            <= c;
    display_select_i <= sel;
    digit_index_i    <= idx;
    pattern_i        <= pat;
    number_i         <= num;
    do begin
      @(negedge clk_i);
      stalled = busy;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Random command word. Ticks dominate so the latches keep moving; most
  // pattern indexes are in range, the rest exercise the ignore path. Numbers
  // mix full 16-bit values, in-range values and the decimal edges.
  task automatic random_word();
    cmd_e        c;
    int          r;
    logic [2:0]  idx;
    logic [15:0] num;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      c = CmdTick;
    end else if (r < 65) begin
      c = CmdNumber;
    end else if (r < 90) begin
      c = CmdPattern;
    end else begin
      c = CmdClear;
    end
    idx = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       num = 16'd9999;
      1:       num = 16'd10000;
      2:       num = 16'hFFFF;
      3:       num = 16'($urandom_range(0, 9999));
      default: num = 16'($urandom);
    endcase
    send_word(c, 1'($urandom), idx, 8'($urandom), num);
  endtask

  // Bursts of random length, separated by random gaps; some bursts are long
  // and some gaps are zero so back-to-back stretches occur as well.
  task automatic random_phase(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < count; i++) begin
        random_word();
        sent++;
      end
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && sent < count) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and let every expected word come out, then a few more
  // cycles so the pipeline is empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write of the polarity register: setup cycle, then access cycle held
  // until pready. Only called with the block idle.
  task automatic set_polarity(bit v);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrCommonAnode;
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_polarity(v);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset polarity (common anode): first tick out of reset,
    // number zero and the largest number, a full scan wrap, pattern edges
    // at both ends of the index range and out-of-range indexes.
    send_word(CmdTick,    1'b0, 3'd0, 8'h00, 16'd0);
    send_word(CmdNumber,  1'b0, 3'd0, 8'h00, 16'd0);
    send_word(CmdNumber,  1'b1, 3'd0, 8'h00, 16'hFFFF);
    repeat (4) send_word(CmdTick, 1'b0, 3'd0, 8'h00, 16'd0);
    send_word(CmdPattern, 1'b0, 3'd0, 8'hFF, 16'd0);
    send_word(CmdPattern, 1'b1, 3'd3, 8'h00, 16'd0);
    send_word(CmdPattern, 1'b0, 3'd4, 8'hA5, 16'd0);
    send_word(CmdPattern, 1'b1, 3'd7, 8'h5A, 16'd0);
    drain();

    // Common cathode: first tick latches bytes written under the old
    // polarity with the new enable sense; decimal edges 9999 and 10000.
    set_polarity(1'b0);
    send_word(CmdTick,    1'b0, 3'd0, 8'h00, 16'd0);
    send_word(CmdNumber,  1'b0, 3'd0, 8'h00, 16'd9999);
    send_word(CmdNumber,  1'b1, 3'd0, 8'h00, 16'd10000);
    send_word(CmdClear,   1'b0, 3'd0, 8'h00, 16'd0);
    send_word(CmdPattern, 1'b1, 3'd2, 8'h80, 16'd0);
    repeat (3) send_word(CmdTick, 1'b0, 3'd0, 8'h00, 16'd0);
    drain();

    // Back to common anode; unused fields all ones.
    set_polarity(1'b1);
    send_word(CmdClear,   1'b1, 3'd7, 8'hFF, 16'hFFFF);
    send_word(CmdNumber,  1'b1, 3'd7, 8'hFF, 16'd1234);
    repeat (2) send_word(CmdTick, 1'b1, 3'd7, 8'hFF, 16'hFFFF);
    drain();

    // Random phases: both polarities for sure, then random ones.
    for (int p = 0; p < RandomPhases; p++) begin
      set_polarity((p < 2) ? 1'(p) : 1'($urandom));
      random_phase(PhaseWords);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_dual_seven_segment_scan_controller_top: done, clean");
    end else begin
      $display("tb_dual_seven_segment_scan_controller_top: done, errors");
    end
    $finish;
  end

endmodule
